// ===== src/chained_hash_map_core_defines.svh =====
// Assertion helpers for the checker of the hash map core.
`ifndef CHAINED_HASH_MAP_CORE_DEFINES_SVH
`define CHAINED_HASH_MAP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CHM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chained_hash_map_core: assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chained_hash_map_core: assertion failed");

`endif

// ===== src/chm_pkg.sv =====
package chm_pkg;

   localparam int HASH_SHIFT = 4;
   localparam int HASH_BITS  = 32 - HASH_SHIFT;
   localparam int DIGIT      = 4;
   localparam int DIV_STEPS  = HASH_BITS / DIGIT;
   localparam int CFG_W      = 9;
   localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd17;

   localparam logic [1:0] KIND_LOOKUP   = 2'd0;
   localparam logic [1:0] KIND_SET      = 2'd1;
   localparam logic [1:0] KIND_REMOVE   = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HEAD,
      S_WALK,
      S_ACT,
      S_POP,
      S_FREE
   } state_type;

endpackage

// ===== src/chm_ram.sv =====
module chm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/chm_div.sv =====
// Remainder of a 28-bit word by a narrow divisor, four quotient bits a cycle.
module chm_div #(
   parameter int MAX_BUCKETS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [chm_pkg::HASH_BITS-1:0]  dividend,
   input  logic [$clog2(MAX_BUCKETS+1)-1:0] divisor,
   output logic                           done,
   output logic [$clog2(MAX_BUCKETS)-1:0] remainder
);

   localparam int NW = $clog2(MAX_BUCKETS + 1);
   localparam int RW = NW + 1;
   localparam int BW = $clog2(MAX_BUCKETS);
   localparam int CW = $clog2(chm_pkg::DIV_STEPS + 1);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [chm_pkg::HASH_BITS-1:0] dvd_ff, dvd_in;
   logic [NW-1:0]                 dsr_ff, dsr_in;
   logic [RW-1:0]                 rem_ff, rem_in;

   always_comb begin
      logic [RW-1:0] r;
      r      = rem_ff;
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      rem_in = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         for (int i = 0; i < chm_pkg::DIGIT; i++) begin
            r = {r[RW-2:0], dvd_ff[chm_pkg::HASH_BITS-1-i]};
            if (r >= {1'b0, dsr_ff}) begin
               r = r - {1'b0, dsr_ff};
            end
         end
         rem_in = r;
         dvd_in = dvd_ff << chm_pkg::DIGIT;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(chm_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[BW-1:0];

endmodule

// ===== src/chained_hash_map_core.sv =====
// An accepted transaction waits in S_HASH for the 7-step bucket remainder unit, reads the
// bucket head in S_HEAD, walks the chain on the entry memories in S_WALK one entry per cycle,
// and answers from S_ACT, or from S_POP or S_FREE for a free-list insert or a removal hit.
// Throughput: one transaction at a time; busy falls in the cycle the result is shown.
// Reset: synchronous; afterwards a clearing pass empties all MAX_BUCKETS bucket heads
// with busy high. Results are strobed for one cycle and cannot be stalled.
module chained_hash_map_core #(
   parameter int MAX_BUCKETS  = 256,
   parameter int POOL_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   // result channel
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [31:0] rsp_stored_value,
   output logic [1:0]  rsp_status,
   // configuration
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   localparam int NW = $clog2(MAX_BUCKETS + 1);   // effective bucket count
   localparam int BW = $clog2(MAX_BUCKETS);       // bucket index
   localparam int PW = $clog2(POOL_ENTRIES + 1);  // entry link, with the empty marker
   localparam int EW = $clog2(POOL_ENTRIES);      // entry memory address
   localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

   chm_pkg::state_type state_ff, state_in;

   // configuration register
   logic [chm_pkg::CFG_W-1:0] bucket_count_ff;
   logic [NW-1:0]             eff_count;

   // control registers
   logic [BW-1:0] clr_ff, clr_in;
   logic [PW-1:0] free_head_ff, free_head_in;
   logic [PW-1:0] mark_ff, mark_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // transaction payload and walk registers
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] value_ff, value_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic [PW-1:0] steps_ff, steps_in;
   logic          found_ff, found_in;
   logic [PW-1:0] hit_next_ff, hit_next_in;
   logic [31:0]   hit_val_ff, hit_val_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   // memory ports
   logic          head_we;
   logic [BW-1:0] head_waddr;
   logic [PW-1:0] head_wdata;
   logic [PW-1:0] head_rdata;
   logic          next_we, key_we, val_we;
   logic [EW-1:0] next_waddr, kv_waddr;
   logic [PW-1:0] next_wdata;
   logic [EW-1:0] ent_raddr;
   logic [PW-1:0] next_rdata;
   logic [31:0]   key_rdata, val_rdata;

   // remainder unit
   logic          accept;
   logic          div_done;
   logic [BW-1:0] bucket;

   assign accept = start && (state_ff == chm_pkg::S_IDLE);

   // Clamp the configured count: zero acts as one, anything above the table saturates.
   always_comb begin
      if (bucket_count_ff == '0) begin
         eff_count = NW'(1);
      end else if (32'(bucket_count_ff) > 32'(MAX_BUCKETS)) begin
         eff_count = NW'(MAX_BUCKETS);
      end else begin
         eff_count = NW'(bucket_count_ff);
      end
   end

   chm_div #(
      .MAX_BUCKETS(MAX_BUCKETS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_key[31:chm_pkg::HASH_SHIFT]),
      .divisor  (eff_count),
      .done     (div_done),
      .remainder(bucket)
   );

   // The remainder register holds the bucket until the next transaction starts.
   chm_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_heads (
      .clock  (clock),
      .wr_en  (head_we),
      .wr_addr(head_waddr),
      .wr_data(head_wdata),
      .rd_addr(bucket),
      .rd_data(head_rdata)
   );

   chm_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_next (
      .clock  (clock),
      .wr_en  (next_we),
      .wr_addr(next_waddr),
      .wr_data(next_wdata),
      .rd_addr(ent_raddr),
      .rd_data(next_rdata)
   );

   chm_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_keys (
      .clock  (clock),
      .wr_en  (key_we),
      .wr_addr(kv_waddr),
      .wr_data(key_ff),
      .rd_addr(ent_raddr),
      .rd_data(key_rdata)
   );

   chm_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_vals (
      .clock  (clock),
      .wr_en  (val_we),
      .wr_addr(kv_waddr),
      .wr_data(value_ff),
      .rd_addr(ent_raddr),
      .rd_data(val_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chm_pkg::S_CLEAR: begin
            if (clr_ff == BW'(MAX_BUCKETS - 1)) begin
               state_in = chm_pkg::S_IDLE;
            end
         end
         chm_pkg::S_IDLE: begin
            if (start) begin
               state_in = chm_pkg::S_HASH;
            end
         end
         chm_pkg::S_HASH: begin
            if (div_done) begin
               state_in = chm_pkg::S_HEAD;
            end
         end
         chm_pkg::S_HEAD: begin
            if (head_rdata >= NIL) begin
               state_in = chm_pkg::S_ACT;
            end else begin
               state_in = chm_pkg::S_WALK;
            end
         end
         chm_pkg::S_WALK: begin
            if (key_rdata == key_ff || next_rdata >= NIL ||
                steps_ff == PW'(POOL_ENTRIES - 1)) begin
               state_in = chm_pkg::S_ACT;
            end
         end
         chm_pkg::S_ACT: begin
            if (kind_ff == chm_pkg::KIND_SET && !found_ff && free_head_ff != NIL) begin
               state_in = chm_pkg::S_POP;
            end else if (kind_ff == chm_pkg::KIND_REMOVE && found_ff) begin
               state_in = chm_pkg::S_FREE;
            end else begin
               state_in = chm_pkg::S_IDLE;
            end
         end
         chm_pkg::S_POP:  state_in = chm_pkg::S_IDLE;
         chm_pkg::S_FREE: state_in = chm_pkg::S_IDLE;
         default:         state_in = chm_pkg::S_IDLE;
      endcase
   end

   // Datapath, memory accesses and result.
   always_comb begin
      clr_in        = clr_ff;
      free_head_in  = free_head_ff;
      mark_in       = mark_ff;
      rsp_valid_in  = 1'b0;
      kind_in       = kind_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      found_in      = found_ff;
      hit_next_in   = hit_next_ff;
      hit_val_in    = hit_val_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      head_we       = 1'b0;
      head_waddr    = bucket;
      head_wdata    = NIL;
      next_we       = 1'b0;
      next_waddr    = cur_ff[EW-1:0];
      next_wdata    = NIL;
      key_we        = 1'b0;
      val_we        = 1'b0;
      kv_waddr      = cur_ff[EW-1:0];
      ent_raddr     = cur_ff[EW-1:0];
      busy          = (state_ff != chm_pkg::S_IDLE);

      case (state_ff)
         chm_pkg::S_CLEAR: begin
            // sweep every head to empty
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NIL;
            clr_in     = clr_ff + 1'b1;
         end
         chm_pkg::S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               key_in   = req_key;
               value_in = req_value;
               found_in = 1'b0;
            end
         end
         chm_pkg::S_HASH: begin
            // bucket head read is issued by the remainder register itself
         end
         chm_pkg::S_HEAD: begin
            head_in   = head_rdata;
            cur_in    = head_rdata;
            prev_in   = NIL;
            steps_in  = '0;
            ent_raddr = head_rdata[EW-1:0];
         end
         chm_pkg::S_WALK: begin
            if (key_rdata == key_ff) begin
               found_in    = 1'b1;
               hit_next_in = next_rdata;
               hit_val_in  = val_rdata;
            end else begin
               // advance along the chain
               prev_in   = cur_ff;
               cur_in    = next_rdata;
               steps_in  = steps_ff + 1'b1;
               ent_raddr = next_rdata[EW-1:0];
            end
         end
         chm_pkg::S_ACT: begin
            rsp_found_in  = found_ff;
            rsp_value_in  = '0;
            rsp_status_in = chm_pkg::STATUS_DONE;
            rsp_valid_in  = 1'b1;
            case (kind_ff)
               chm_pkg::KIND_LOOKUP: begin
                  if (found_ff) begin
                     rsp_value_in = hit_val_ff;
                  end else begin
                     rsp_status_in = chm_pkg::STATUS_MISS;
                  end
               end
               chm_pkg::KIND_SET: begin
                  if (found_ff) begin
                     // update in place
                     val_we   = 1'b1;
                     kv_waddr = cur_ff[EW-1:0];
                  end else if (free_head_ff != NIL) begin
                     // fetch the successor of the free-list head first
                     ent_raddr    = free_head_ff[EW-1:0];
                     rsp_valid_in = 1'b0;
                  end else if (mark_ff != NIL) begin
                     key_we     = 1'b1;
                     val_we     = 1'b1;
                     kv_waddr   = mark_ff[EW-1:0];
                     next_we    = 1'b1;
                     next_waddr = mark_ff[EW-1:0];
                     next_wdata = head_ff;
                     head_we    = 1'b1;
                     head_wdata = mark_ff;
                     mark_in    = mark_ff + 1'b1;
                  end else begin
                     rsp_status_in = chm_pkg::STATUS_FULL;
                  end
               end
               chm_pkg::KIND_REMOVE: begin
                  if (found_ff) begin
                     // unlink; the freed entry is pushed next cycle
                     if (prev_ff == NIL) begin
                        head_we    = 1'b1;
                        head_wdata = hit_next_ff;
                     end else begin
                        next_we    = 1'b1;
                        next_waddr = prev_ff[EW-1:0];
                        next_wdata = hit_next_ff;
                     end
                     rsp_valid_in = 1'b0;
                  end else begin
                     rsp_status_in = chm_pkg::STATUS_MISS;
                  end
               end
               default: begin
                  // undefined kind: drop, answer done
                  rsp_found_in = 1'b0;
               end
            endcase
         end
         chm_pkg::S_POP: begin
            free_head_in  = next_rdata;
            key_we        = 1'b1;
            val_we        = 1'b1;
            kv_waddr      = free_head_ff[EW-1:0];
            next_we       = 1'b1;
            next_waddr    = free_head_ff[EW-1:0];
            next_wdata    = head_ff;
            head_we       = 1'b1;
            head_wdata    = free_head_ff;
            rsp_found_in  = 1'b0;
            rsp_value_in  = '0;
            rsp_status_in = chm_pkg::STATUS_DONE;
            rsp_valid_in  = 1'b1;
         end
         chm_pkg::S_FREE: begin
            next_we       = 1'b1;
            next_waddr    = cur_ff[EW-1:0];
            next_wdata    = free_head_ff;
            free_head_in  = cur_ff;
            rsp_found_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = chm_pkg::STATUS_DONE;
            rsp_valid_in  = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= chm_pkg::S_CLEAR;
         bucket_count_ff <= chm_pkg::BUCKET_COUNT_RESET;
         clr_ff          <= '0;
         free_head_ff    <= NIL;
         mark_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bucket_count_ff <= csr_wr_data;
         end
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      found_ff      <= found_in;
      hit_next_ff   <= hit_next_in;
      hit_val_ff    <= hit_val_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_stored_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== src/chm_chk.sv =====
`include "chained_hash_map_core_defines.svh"

module chm_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_found,
   input logic [31:0] rsp_stored_value,
   input logic [1:0]  rsp_status
);

   `CHM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CHM_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `CHM_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `CHM_ASSERT_NOW(a_value_hit, clock, reset, rsp_valid && rsp_stored_value != 32'd0, rsp_found && rsp_status == chm_pkg::STATUS_DONE)
   `CHM_ASSERT_NOW(a_full_miss, clock, reset, rsp_valid && rsp_status == chm_pkg::STATUS_FULL, !rsp_found)

endmodule

bind chained_hash_map_core chm_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_found       (rsp_found),
   .rsp_stored_value(rsp_stored_value),
   .rsp_status      (rsp_status)
);
